/* rtl/euler_to_rotation_matrix_defines.svh */
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef EULER_TO_ROTATION_MATRIX_DEFINES_SVH
`define EULER_TO_ROTATION_MATRIX_DEFINES_SVH

// same-cycle implication, disabled in reset
`define E2R_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define E2R_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/e2r_pkg.sv */
// ----------------------------------------------------------------------------
// e2r_pkg
// Types, constants and arithmetic helpers of the Euler to rotation matrix block.
// ----------------------------------------------------------------------------
package e2r_pkg;

    localparam int CORDIC_N   = 16;
    localparam int NUM_LANES  = 3;
    localparam int NUM_STAGES = CORDIC_N + 4;

    localparam logic signed [16:0] FULL_TURN  = 17'sd46080;
    localparam logic signed [16:0] HALF_TURN  = 17'sd23040;
    localparam logic signed [16:0] QUARTER    = 17'sd11520;
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [24:0] z;
        logic               flip;
    } cord_lane_t;

    typedef struct packed {
        logic load;
        logic valid;
    } stage_ctl_t;

    function automatic logic signed [24:0] atan_lut(input logic [3:0] i);
        logic signed [24:0] r;
        unique case (i)
            4'd0:    r = 25'sd2949120;
            4'd1:    r = 25'sd1740967;
            4'd2:    r = 25'sd919879;
            4'd3:    r = 25'sd466945;
            4'd4:    r = 25'sd234379;
            4'd5:    r = 25'sd117304;
            4'd6:    r = 25'sd58666;
            4'd7:    r = 25'sd29335;
            4'd8:    r = 25'sd14668;
            4'd9:    r = 25'sd7334;
            4'd10:   r = 25'sd3667;
            4'd11:   r = 25'sd1833;
            4'd12:   r = 25'sd917;
            4'd13:   r = 25'sd458;
            4'd14:   r = 25'sd229;
            4'd15:   r = 25'sd115;
            default: r = 25'sd0;
        endcase
        return r;
    endfunction

    // Q.30 product, rounded by floor((p + 2^29) / 2^30)
    function automatic logic signed [32:0] mulq30(input logic signed [32:0] a,
                                                  input logic signed [32:0] b);
        logic signed [65:0] p;
        p = $signed({{33{a[32]}}, a}) * $signed({{33{b[32]}}, b});
        p = p + (66'sd1 <<< 29);
        return p[62:30];
    endfunction

    function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [18:0] q;
        logic signed [15:0] r;
        t = $signed({v[33], v}) + 35'sd32768;
        q = t[34:16];
        if (q > 19'sd16384)
            r = 16'sd16384;
        else if (q < -19'sd16384)
            r = -16'sd16384;
        else
            r = q[15:0];
        return r;
    endfunction

endpackage

/* rtl/euler_to_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix
// ZYX Euler angles (degrees * 128) to a 3x3 rotation matrix in Q2.14.
//
//   channel   valid        stall        fields
//   angle     angle_valid  angle_stall  yaw_deg, pitch_deg, roll_deg
//   rot       rot_valid    rot_stall    rot_00 .. rot_22
//
// One beat per cycle while rot_stall is low; stages: prep, 16 CORDIC cells, 3 matrix.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// close up behind a stalled output.
// Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix
    import e2r_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               angle_valid,
    output logic               angle_stall,
    input  logic signed [15:0] yaw_deg,
    input  logic signed [15:0] pitch_deg,
    input  logic signed [15:0] roll_deg,
    output logic               rot_valid,
    input  logic               rot_stall,
    output logic signed [15:0] rot_00,
    output logic signed [15:0] rot_01,
    output logic signed [15:0] rot_02,
    output logic signed [15:0] rot_10,
    output logic signed [15:0] rot_11,
    output logic signed [15:0] rot_12,
    output logic signed [15:0] rot_20,
    output logic signed [15:0] rot_21,
    output logic signed [15:0] rot_22
);

    logic [NUM_STAGES-1:0] v;
    logic [NUM_STAGES-1:0] en;
    stage_ctl_t            ctl [NUM_STAGES];
    cord_lane_t            lane [CORDIC_N+1][NUM_LANES];

    always_comb
    begin
        en[NUM_STAGES-1] = !v[NUM_STAGES-1] || !rot_stall;
        for (int k = NUM_STAGES-2; k >= 0; k--)
            en[k] = !v[k] || en[k+1];
        ctl[0].load  = en[0];
        ctl[0].valid = angle_valid;
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            ctl[k].load  = en[k];
            ctl[k].valid = v[k-1];
        end
    end

    assign angle_stall = !en[0];
    assign rot_valid   = v[NUM_STAGES-1];

    e2r_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl[0]),
        .yaw_deg   (yaw_deg),
        .pitch_deg (pitch_deg),
        .roll_deg  (roll_deg),
        .lane_q    (lane[0]),
        .valid_q   (v[0])
    );

    for (genvar g = 0; g < CORDIC_N; g++)
    begin : g_cell
        e2r_cordic_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl[g+1]),
            .idx     (4'(g)),
            .lane_d  (lane[g]),
            .lane_q  (lane[g+1]),
            .valid_q (v[g+1])
        );
    end

    e2r_matrix u_matrix (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl[CORDIC_N+1:CORDIC_N+3]),
        .lane_d  (lane[CORDIC_N]),
        .valid_q (v[CORDIC_N+3:CORDIC_N+1]),
        .rot_00  (rot_00),
        .rot_01  (rot_01),
        .rot_02  (rot_02),
        .rot_10  (rot_10),
        .rot_11  (rot_11),
        .rot_12  (rot_12),
        .rot_20  (rot_20),
        .rot_21  (rot_21),
        .rot_22  (rot_22)
    );

endmodule

/* rtl/e2r_prep.sv */
// ----------------------------------------------------------------------------
// e2r_prep
// Wraps and folds the three angles and loads the CORDIC start vectors.
// ----------------------------------------------------------------------------
module e2r_prep
    import e2r_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  stage_ctl_t         ctl,
    input  logic signed [15:0] yaw_deg,
    input  logic signed [15:0] pitch_deg,
    input  logic signed [15:0] roll_deg,
    output cord_lane_t         lane_q [NUM_LANES],
    output logic               valid_q
);

    logic signed [16:0] ang  [NUM_LANES];
    cord_lane_t         lane_next [NUM_LANES];
    cord_lane_t         lane_reg  [NUM_LANES];
    logic               valid_reg;

    always_comb
    begin
        logic signed [16:0] t;
        logic               f;
        ang[0] = {yaw_deg[15], yaw_deg};
        ang[1] = -$signed({pitch_deg[15], pitch_deg});
        ang[2] = -$signed({roll_deg[15], roll_deg});
        for (int k = 0; k < NUM_LANES; k++)
        begin
            t = ang[k];
            f = 1'b0;
            if (t >= HALF_TURN)
                t = t - FULL_TURN;
            else if (t < -HALF_TURN)
                t = t + FULL_TURN;
            if (t > QUARTER)
            begin
                t = t - HALF_TURN;
                f = 1'b1;
            end
            else if (t < -QUARTER)
            begin
                t = t + HALF_TURN;
                f = 1'b1;
            end
            lane_next[k].x    = CORDIC_GAIN;
            lane_next[k].y    = 33'sd0;
            lane_next[k].z    = {{8{t[16]}}, t} <<< 9;
            lane_next[k].flip = f;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ctl.load)
            valid_reg <= ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            lane_reg <= lane_next;
    end

    assign lane_q  = lane_reg;
    assign valid_q = valid_reg;

endmodule

/* rtl/e2r_cordic_cell.sv */
// ----------------------------------------------------------------------------
// e2r_cordic_cell
// One rotation-mode CORDIC micro-rotation for the three angle lanes.
// ----------------------------------------------------------------------------
module e2r_cordic_cell
    import e2r_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  stage_ctl_t ctl,
    input  logic [3:0] idx,
    input  cord_lane_t lane_d [NUM_LANES],
    output cord_lane_t lane_q [NUM_LANES],
    output logic       valid_q
);

    cord_lane_t         lane_next [NUM_LANES];
    cord_lane_t         lane_reg  [NUM_LANES];
    logic               valid_reg;
    logic signed [24:0] atan_val;

    assign atan_val = atan_lut(idx);

    always_comb
    begin
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        for (int k = 0; k < NUM_LANES; k++)
        begin
            dx = lane_d[k].y >>> idx;
            dy = lane_d[k].x >>> idx;
            lane_next[k].flip = lane_d[k].flip;
            if (!lane_d[k].z[24])
            begin
                lane_next[k].x = lane_d[k].x - dx;
                lane_next[k].y = lane_d[k].y + dy;
                lane_next[k].z = lane_d[k].z - atan_val;
            end
            else
            begin
                lane_next[k].x = lane_d[k].x + dx;
                lane_next[k].y = lane_d[k].y - dy;
                lane_next[k].z = lane_d[k].z + atan_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ctl.load)
            valid_reg <= ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            lane_reg <= lane_next;
    end

    assign lane_q  = lane_reg;
    assign valid_q = valid_reg;

endmodule

/* rtl/e2r_matrix.sv */
// ----------------------------------------------------------------------------
// e2r_matrix
// Products, sums and Q2.14 rounding of the nine matrix entries.
// ----------------------------------------------------------------------------
module e2r_matrix
    import e2r_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  stage_ctl_t         ctl [3],
    input  cord_lane_t         lane_d [NUM_LANES],
    output logic [2:0]         valid_q,
    output logic signed [15:0] rot_00,
    output logic signed [15:0] rot_01,
    output logic signed [15:0] rot_02,
    output logic signed [15:0] rot_10,
    output logic signed [15:0] rot_11,
    output logic signed [15:0] rot_12,
    output logic signed [15:0] rot_20,
    output logic signed [15:0] rot_21,
    output logic signed [15:0] rot_22
);

    logic [2:0] valid_reg;

    logic signed [32:0] s_val [NUM_LANES];
    logic signed [32:0] c_val [NUM_LANES];

    // first product stage
    logic signed [32:0] casb_reg, sasb_reg, p00_reg, p10_reg, p21_reg, p22_reg;
    logic signed [32:0] sacr_reg, sasr_reg, cacr_reg, casr_reg;
    logic signed [32:0] sb_reg, sr_reg, cr_reg;

    // second product stage
    logic signed [32:0] q01, q02, q11, q12;
    logic signed [33:0] e_reg [9];
    logic signed [33:0] e_next [9];

    logic signed [15:0] rot_reg [9];

    always_comb
    begin
        for (int k = 0; k < NUM_LANES; k++)
        begin
            s_val[k] = lane_d[k].flip ? -lane_d[k].y : lane_d[k].y;
            c_val[k] = lane_d[k].flip ? -lane_d[k].x : lane_d[k].x;
        end
    end

    always_comb
    begin
        q01 = mulq30(casb_reg, sr_reg);
        q02 = mulq30(casb_reg, cr_reg);
        q11 = mulq30(sasb_reg, sr_reg);
        q12 = mulq30(sasb_reg, cr_reg);
        e_next[0] = {p00_reg[32], p00_reg};
        e_next[1] = {q01[32], q01} - {sacr_reg[32], sacr_reg};
        e_next[2] = {q02[32], q02} + {sasr_reg[32], sasr_reg};
        e_next[3] = {p10_reg[32], p10_reg};
        e_next[4] = {q11[32], q11} + {cacr_reg[32], cacr_reg};
        e_next[5] = {q12[32], q12} - {casr_reg[32], casr_reg};
        e_next[6] = -$signed({sb_reg[32], sb_reg});
        e_next[7] = {p21_reg[32], p21_reg};
        e_next[8] = {p22_reg[32], p22_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 3'b000;
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (ctl[k].load)
                    valid_reg[k] <= ctl[k].valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl[0].load)
        begin
            casb_reg <= mulq30(c_val[0], s_val[1]);
            sasb_reg <= mulq30(s_val[0], s_val[1]);
            p00_reg  <= mulq30(c_val[0], c_val[1]);
            p10_reg  <= mulq30(s_val[0], c_val[1]);
            p21_reg  <= mulq30(c_val[1], s_val[2]);
            p22_reg  <= mulq30(c_val[1], c_val[2]);
            sacr_reg <= mulq30(s_val[0], c_val[2]);
            sasr_reg <= mulq30(s_val[0], s_val[2]);
            cacr_reg <= mulq30(c_val[0], c_val[2]);
            casr_reg <= mulq30(c_val[0], s_val[2]);
            sb_reg   <= s_val[1];
            sr_reg   <= s_val[2];
            cr_reg   <= c_val[2];
        end
        if (ctl[1].load)
            e_reg <= e_next;
        if (ctl[2].load)
        begin
            for (int k = 0; k < 9; k++)
                rot_reg[k] <= to_q14(e_reg[k]);
        end
    end

    assign valid_q = valid_reg;
    assign rot_00  = rot_reg[0];
    assign rot_01  = rot_reg[1];
    assign rot_02  = rot_reg[2];
    assign rot_10  = rot_reg[3];
    assign rot_11  = rot_reg[4];
    assign rot_12  = rot_reg[5];
    assign rot_20  = rot_reg[6];
    assign rot_21  = rot_reg[7];
    assign rot_22  = rot_reg[8];

endmodule

/* rtl/e2r_checker.sv */
// ----------------------------------------------------------------------------
// e2r_checker
// Port-level checks of the rotation matrix block, bound to the top level.
// ----------------------------------------------------------------------------
`include "euler_to_rotation_matrix_defines.svh"

module e2r_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               angle_valid,
    input logic               angle_stall,
    input logic               rot_valid,
    input logic               rot_stall,
    input logic signed [15:0] rot_00,
    input logic signed [15:0] rot_01,
    input logic signed [15:0] rot_02,
    input logic signed [15:0] rot_10,
    input logic signed [15:0] rot_11,
    input logic signed [15:0] rot_12,
    input logic signed [15:0] rot_20,
    input logic signed [15:0] rot_21,
    input logic signed [15:0] rot_22
);

    `E2R_ASSERT_NOW(a_stall_only_when_full, angle_stall, rot_valid && rot_stall, "input stalled while output free")
    `E2R_ASSERT_NEXT(a_in_hold, angle_valid && angle_stall, angle_valid, "input beat dropped under stall")
    `E2R_ASSERT_NOW(a_entry_range, rot_valid, (rot_00 >= -16'sd16384) && (rot_00 <= 16'sd16384) && (rot_22 >= -16'sd16384) && (rot_22 <= 16'sd16384) && (rot_20 >= -16'sd16384) && (rot_20 <= 16'sd16384), "matrix entry out of range")
    `E2R_ASSERT_NEXT(a_valid_hold, rot_valid && rot_stall, rot_valid, "result dropped under stall")
    `E2R_ASSERT_NEXT(a_beat_hold, rot_valid && rot_stall, $stable(rot_00) && $stable(rot_01) && $stable(rot_02) && $stable(rot_10) && $stable(rot_11) && $stable(rot_12) && $stable(rot_20) && $stable(rot_21) && $stable(rot_22), "stalled beat changed")

endmodule

bind euler_to_rotation_matrix e2r_checker u_e2r_checker (.*);
